// File: rtl/core/ctss_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and lookup tables for the chiptune step sequencer synth.
// Has no dependencies; every other file of the block refers to it by scoped names.
package ctss_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EFF_NONE     = 3'd0,
		EFF_SLIDE    = 3'd1,
		EFF_VIBRATO  = 3'd2,
		EFF_DROP     = 3'd3,
		EFF_FADE_IN  = 3'd4,
		EFF_FADE_OUT = 3'd5
	} effect_t;

	localparam logic [2:0] WAVE_TRIANGLE = 3'd0;
	localparam logic [2:0] WAVE_SQUARE   = 3'd1;
	localparam logic [2:0] WAVE_SAW      = 3'd2;
	localparam logic [2:0] WAVE_PULSE    = 3'd3;
	localparam logic [2:0] WAVE_NOISE    = 3'd4;

	localparam logic [2:0] CFG_A4_INC     = 3'd0;
	localparam logic [2:0] CFG_FRAC_INC   = 3'd1;
	localparam logic [2:0] CFG_VIB_RATE   = 3'd2;
	localparam logic [2:0] CFG_LOOP_START = 3'd3;
	localparam logic [2:0] CFG_LOOP_END   = 3'd4;

	localparam int MUL_AW = 24;
	localparam int MUL_BW = 18;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	// Pitch offset that maps 1/16 semitone pitch to four octaves below A4.
	localparam logic [11:0] PITCH_BIAS = 12'd240;
	localparam logic [23:0] AMP_SCALE  = 24'd19660;
	// floor(2^16 / 7), the reciprocal used for the final divide by seven.
	localparam logic [17:0] RECIP7     = 18'd9362;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_RD0, ST_RD1, ST_RD2, ST_P16, ST_OCT, ST_SF,
		ST_INC, ST_K, ST_G, ST_WL, ST_WH, ST_DQ, ST_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] effect;
		logic [2:0] loud;
		logic [2:0] wave;
		logic [5:0] pitch;
	} step_t;

	function automatic logic [16:0] semi_ratio(input logic [3:0] idx);
		logic [16:0] v;
		case (idx)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd69433;
			4'd2:    v = 17'd73562;
			4'd3:    v = 17'd77936;
			4'd4:    v = 17'd82570;
			4'd5:    v = 17'd87480;
			4'd6:    v = 17'd92682;
			4'd7:    v = 17'd98193;
			4'd8:    v = 17'd104032;
			4'd9:    v = 17'd110218;
			4'd10:   v = 17'd116772;
			4'd11:   v = 17'd123715;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] fine_ratio(input logic [3:0] idx);
		logic [16:0] v;
		case (idx)
			4'd0:    v = 17'd65536;
			4'd1:    v = 17'd65773;
			4'd2:    v = 17'd66011;
			4'd3:    v = 17'd66250;
			4'd4:    v = 17'd66489;
			4'd5:    v = 17'd66730;
			4'd6:    v = 17'd66971;
			4'd7:    v = 17'd67213;
			4'd8:    v = 17'd67456;
			4'd9:    v = 17'd67700;
			4'd10:   v = 17'd67945;
			4'd11:   v = 17'd68191;
			4'd12:   v = 17'd68438;
			4'd13:   v = 17'd68685;
			4'd14:   v = 17'd68933;
			default: v = 17'd69183;
		endcase
		return v;
	endfunction

	function automatic logic [10:0] vib_thresh(input logic [2:0] idx);
		logic [10:0] v;
		case (idx)
			3'd0:    v = 11'd41;
			3'd1:    v = 11'd123;
			3'd2:    v = 11'd207;
			3'd3:    v = 11'd295;
			3'd4:    v = 11'd389;
			3'd5:    v = 11'd494;
			3'd6:    v = 11'd618;
			default: v = 11'd792;
		endcase
		return v;
	endfunction

	// Sine offset in 1/16 semitone, rounded, from a 12-bit vibrato phase.
	function automatic logic signed [4:0] vib_offset(input logic [11:0] ph);
		logic [10:0] r;
		logic [4:0]  mag;
		r   = {1'b0, ph[9:0]};
		mag = 5'd0;
		if (ph[10])
			r = 11'd1024 - r;
		for (int i = 0; i < 8; i++)
			if (r >= vib_thresh(3'(i)))
				mag = mag + 5'd1;
		return ph[11] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [31:0] xorshift32(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

// File: rtl/core/chiptune_step_sequencer_synth_top.sv
`timescale 1ns / 1ps
// Top level of the chiptune step sequencer synth: pattern store, sequencer and datapath.
// Depends on ctss_pkg for codes, tables and the state type.

// Each tick word yields one audio sample; write, start and stop words update the
// pattern or playback state and yield no output word. A tick occupies the block through
// a run of states in which a small sequencer reuses the single shared 24x18 multiplier
// for the slide or vibrato product, the pitch ratio, the phase increment and the
// amplitude chain, plus two reads of the pattern memory; a tick heard while stopped
// goes straight to the output with a silent sample, and non-tick words complete in the
// cycle they are accepted. The finished sample sits in an output register, so a new word is taken
// while the previous sample still waits for out_ready. The pattern memory needs no
// clearing pass: per-step valid bits make unwritten steps read as silent.
module chiptune_step_sequencer_synth_top #(
	parameter int STEP_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [4:0]  step_slot,
	input  logic [5:0]  note_pitch,
	input  logic [2:0]  wave_shape,
	input  logic [2:0]  loudness,
	input  logic [2:0]  effect_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] audio_sample,
	output logic        is_playing,
	output logic [5:0]  current_step,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int AW = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;
	localparam int PW = $clog2(STEP_COUNT + 1);

	ctss_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [23:0] a4_inc_q;
	logic [15:0] frac_inc_q;
	logic [12:0] vib_rate_q;
	logic [4:0]  loop_start_q;
	logic [5:0]  loop_end_q;

	// Playback state.
	logic          running_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   frac_q;
	logic [23:0]   phase_q;
	logic [31:0]   lfsr_q;

	// Pattern memory and its valid bits.
	ctss_pkg::step_t     mem [STEP_COUNT];
	logic [STEP_COUNT-1:0] vld_q;
	ctss_pkg::step_t     rd_q;
	logic                rd_vld_q;
	logic [AW-1:0]       rd_addr;
	ctss_pkg::step_t     rd_entry;

	// Working registers of one tick.
	ctss_pkg::step_t    ent_q;
	logic [5:0]         prev_pitch_q;
	logic signed [11:0] p16_q;
	logic [2:0]         oct_q;
	logic [23:0]        inc_q;
	logic [34:0]        g_q;
	logic [33:0]        plo_q;
	logic [17:0]        q_q;
	logic signed [15:0] sample_q;

	// Shared multiplier.
	logic [ctss_pkg::MUL_AW-1:0] mul_a;
	logic [ctss_pkg::MUL_BW-1:0] mul_b;
	logic [ctss_pkg::MUL_PW-1:0] prod_q;

	logic accept, tick_accept, write_en, out_load;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ctss_pkg::ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign tick_accept = accept && (kind == ctss_pkg::KIND_TICK);
	assign write_en    = accept && (kind == ctss_pkg::KIND_WRITE) &&
		(7'(step_slot) < 7'(STEP_COUNT));
	assign out_load    = (state_q == ctss_pkg::ST_OUT) && (!out_valid || out_ready);
	assign rd_entry    = rd_vld_q ? rd_q : '0;

	// Derived step values.
	logic [9:0]         pitch16, prev16;
	logic signed [10:0] slide_d;
	logic [9:0]         slide_m;
	logic [16:0]        fade;
	logic               loop_ok;

	assign pitch16 = {ent_q.pitch, 4'b0000};
	// The previous step arrives from memory in the same cycle that the slide product
	// is issued, so it is taken straight from the read port there.
	assign prev16  = {(state_q == ctss_pkg::ST_RD2) ? rd_entry.pitch : prev_pitch_q, 4'b0000};
	assign slide_d = $signed({1'b0, pitch16}) - $signed({1'b0, prev16});
	assign slide_m = slide_d[10] ? 10'(-slide_d) : 10'(slide_d);
	assign loop_ok = (loop_end_q > 6'(loop_start_q)) && (7'(loop_end_q) <= 7'(STEP_COUNT));

	always_comb begin
		case (ent_q.effect)
			ctss_pkg::EFF_FADE_IN:  fade = {1'b0, frac_q};
			ctss_pkg::EFF_FADE_OUT: fade = 17'h10000 - {1'b0, frac_q};
			default:                fade = 17'h10000;
		endcase
	end

	// Waveform value in Q15 from the current phase; the noise wave uses the next
	// generator state, which is committed at the end of a noise tick with nonzero loudness.
	logic [31:0]        noise_nx;
	logic [23:0]        tri_d;
	logic signed [17:0] w_s;
	logic [16:0]        w_mag;

	assign noise_nx = ctss_pkg::xorshift32(lfsr_q);
	assign tri_d    = phase_q[23] ? (phase_q - 24'h800000) : (24'h800000 - phase_q);

	always_comb begin
		case (ent_q.wave)
			ctss_pkg::WAVE_TRIANGLE: w_s = $signed({1'b0, tri_d[23:7]}) - 18'sd32768;
			ctss_pkg::WAVE_SQUARE:   w_s = phase_q[23] ? -18'sd32768 : 18'sd32768;
			ctss_pkg::WAVE_SAW:      w_s = $signed({2'b00, phase_q[23:8]}) - 18'sd32768;
			ctss_pkg::WAVE_PULSE:
				w_s = (phase_q[23:22] == 2'b00) ? 18'sd32768 : -18'sd32768;
			ctss_pkg::WAVE_NOISE:    w_s = $signed({2'b00, noise_nx[15:0]}) - 18'sd32768;
			default:                 w_s = 18'sd0;
		endcase
	end
	assign w_mag = w_s[17] ? 17'(-w_s) : 17'(w_s);

	// Pitch after the effect: from the slide or vibrato product, or from the step position for a drop.
	logic [26:0]        slide_ceil;
	logic signed [11:0] slide_off;
	logic [23:0]        drop_sum;
	logic signed [11:0] p16_new;

	assign slide_ceil = {1'b0, prod_q[25:0]} + 27'h00FFFF;
	assign slide_off  = slide_d[10] ? -$signed({1'b0, slide_ceil[26:16]}) :
		$signed({2'b00, prod_q[25:16]});
	assign drop_sum   = {1'b0, frac_q, 7'b0} + {2'b00, frac_q, 6'b0};

	always_comb begin
		case (ent_q.effect)
			ctss_pkg::EFF_SLIDE:   p16_new = $signed({2'b00, prev16}) + slide_off;
			ctss_pkg::EFF_VIBRATO: p16_new = $signed({2'b00, pitch16}) +
				12'(ctss_pkg::vib_offset(prod_q[27:16]));
			ctss_pkg::EFF_DROP:    p16_new = $signed({2'b00, pitch16}) -
				$signed({4'b0000, drop_sum[23:16]});
			default:               p16_new = $signed({2'b00, pitch16});
		endcase
	end

	// Octave and remainder of the biased pitch: u / 192 by compares.
	logic [10:0] u_pitch;
	logic [2:0]  oct;
	logic [7:0]  rem;

	assign u_pitch = 11'(p16_q + $signed(ctss_pkg::PITCH_BIAS));
	always_comb begin
		oct = 3'd0;
		for (int k = 1; k <= 6; k++)
			if (u_pitch >= 11'(192 * k))
				oct = oct + 3'd1;
	end
	assign rem = 8'(u_pitch - 11'd192 * {8'b0, oct});

	// Amplitude: sum of the two partial products, then divide by seven.
	logic [52:0] amp_sum;
	logic [17:0] est;
	logic [20:0] est_r;
	logic [17:0] quot;
	logic signed [15:0] sample_new;
	logic [16:0] frac_sum;

	assign amp_sum = {prod_q[35:0], 17'b0} + {19'b0, plo_q};
	assign est     = prod_q[33:16];
	assign est_r   = 21'(q_q) - 21'(est) * 21'd7;
	assign quot    = est + ((est_r >= 21'd7) ? 18'd1 : 18'd0) +
		((est_r >= 21'd14) ? 18'd1 : 18'd0);
	assign frac_sum = {1'b0, frac_q} + {1'b0, frac_inc_q};

	always_comb begin
		if (w_s[17])
			sample_new = (quot > 18'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, quot}));
		else
			sample_new = (quot > 18'd32767) ? 16'sd32767 : $signed(16'(quot));
	end

	// Sequencer: next state, memory address and multiplier operands.
	always_comb begin
		state_d = state_q;
		rd_addr = AW'(pos_q);
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			ctss_pkg::ST_IDLE: if (tick_accept) state_d = ctss_pkg::ST_CHK;
			ctss_pkg::ST_CHK:  state_d = ctss_pkg::ST_RD0;
			ctss_pkg::ST_RD0:  state_d = running_q ? ctss_pkg::ST_RD1 : ctss_pkg::ST_OUT;
			ctss_pkg::ST_RD1: begin
				rd_addr = (pos_q == '0) ? '0 : AW'(pos_q - PW'(1));
				state_d = ctss_pkg::ST_RD2;
			end
			ctss_pkg::ST_RD2: begin
				if (ent_q.effect == ctss_pkg::EFF_SLIDE) begin
					mul_a = 24'(frac_q);
					mul_b = 18'(slide_m);
				end else begin
					mul_a = 24'({pos_q, frac_q});
					mul_b = 18'(vib_rate_q);
				end
				state_d = ctss_pkg::ST_P16;
			end
			ctss_pkg::ST_P16:  state_d = ctss_pkg::ST_OCT;
			ctss_pkg::ST_OCT: begin
				mul_a   = 24'(ctss_pkg::semi_ratio(rem[7:4]));
				mul_b   = 18'(ctss_pkg::fine_ratio(rem[3:0]));
				state_d = ctss_pkg::ST_SF;
			end
			ctss_pkg::ST_SF: begin
				mul_a   = a4_inc_q;
				mul_b   = 18'(prod_q[32:16]);
				state_d = ctss_pkg::ST_INC;
			end
			ctss_pkg::ST_INC: begin
				mul_a   = ctss_pkg::AMP_SCALE;
				mul_b   = 18'(ent_q.loud);
				state_d = ctss_pkg::ST_K;
			end
			ctss_pkg::ST_K: begin
				mul_a   = 24'(prod_q[17:0]);
				mul_b   = 18'(fade);
				state_d = ctss_pkg::ST_G;
			end
			ctss_pkg::ST_G: begin
				mul_a   = 24'(w_mag);
				mul_b   = {1'b0, prod_q[16:0]};
				state_d = ctss_pkg::ST_WL;
			end
			ctss_pkg::ST_WL: begin
				mul_a   = 24'(w_mag);
				mul_b   = g_q[34:17];
				state_d = ctss_pkg::ST_WH;
			end
			ctss_pkg::ST_WH:   state_d = ctss_pkg::ST_DQ;
			ctss_pkg::ST_DQ: begin
				mul_a   = 24'(q_q);
				mul_b   = ctss_pkg::RECIP7;
				state_d = ctss_pkg::ST_FIN;
			end
			ctss_pkg::ST_FIN:  state_d = ctss_pkg::ST_OUT;
			ctss_pkg::ST_OUT:  if (out_load) state_d = ctss_pkg::ST_IDLE;
			default:           state_d = ctss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ctss_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// The multiplier result is always registered before use.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Pattern memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (write_en)
			mem[AW'(step_slot)] <= '{effect: effect_code, loud: loudness,
				wave: wave_shape, pitch: note_pitch};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (write_en)
				vld_q[AW'(step_slot)] <= 1'b1;
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a4_inc_q     <= 24'd334783;
			frac_inc_q   <= 16'd356;
			vib_rate_q   <= 13'd205;
			loop_start_q <= 5'd0;
			loop_end_q   <= 6'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ctss_pkg::CFG_A4_INC:     a4_inc_q     <= cfg_data;
				ctss_pkg::CFG_FRAC_INC:   frac_inc_q   <= cfg_data[15:0];
				ctss_pkg::CFG_VIB_RATE:   vib_rate_q   <= cfg_data[12:0];
				ctss_pkg::CFG_LOOP_START: loop_start_q <= cfg_data[4:0];
				ctss_pkg::CFG_LOOP_END:   loop_end_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			pos_q        <= '0;
			frac_q       <= '0;
			phase_q      <= '0;
			lfsr_q       <= 32'd1;
			ent_q        <= '0;
			prev_pitch_q <= '0;
			p16_q        <= '0;
			oct_q        <= '0;
			inc_q        <= '0;
			g_q          <= '0;
			plo_q        <= '0;
			q_q          <= '0;
			sample_q     <= '0;
		end else begin
			if (accept && kind == ctss_pkg::KIND_START) begin
				pos_q     <= '0;
				frac_q    <= '0;
				phase_q   <= '0;
				running_q <= 1'b1;
			end
			if (accept && kind == ctss_pkg::KIND_STOP)
				running_q <= 1'b0;
			case (state_q)
				ctss_pkg::ST_CHK: begin
					// End of pattern: wrap into the loop range or stop.
					if (running_q && 7'(pos_q) >= 7'(STEP_COUNT)) begin
						if (loop_ok) begin
							pos_q  <= PW'(loop_start_q);
							frac_q <= '0;
						end else begin
							running_q <= 1'b0;
						end
					end
				end
				ctss_pkg::ST_RD0: if (!running_q) sample_q <= '0;
				ctss_pkg::ST_RD1: ent_q <= rd_entry;
				ctss_pkg::ST_RD2: prev_pitch_q <= rd_entry.pitch;
				ctss_pkg::ST_P16: p16_q <= p16_new;
				ctss_pkg::ST_OCT: oct_q <= oct;
				ctss_pkg::ST_INC: inc_q <= 24'(prod_q >> (5'd20 - {2'b00, oct_q}));
				ctss_pkg::ST_G:   g_q <= prod_q[34:0];
				ctss_pkg::ST_WL:  plo_q <= prod_q[33:0];
				ctss_pkg::ST_WH:  q_q <= amp_sum[48:31];
				ctss_pkg::ST_FIN: begin
					sample_q <= sample_new;
					if (ent_q.loud != 3'd0 && ent_q.wave == ctss_pkg::WAVE_NOISE)
						lfsr_q <= noise_nx;
					phase_q <= phase_q + inc_q;
					frac_q  <= frac_sum[15:0];
					if (frac_sum[16])
						pos_q <= pos_q + PW'(1);
				end
				default: ;
			endcase
		end
	end

	// Output register: holds the finished sample until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			audio_sample <= '0;
			is_playing   <= 1'b0;
			current_step <= '0;
		end else if (out_load) begin
			out_valid    <= 1'b1;
			audio_sample <= sample_q;
			is_playing   <= running_q;
			current_step <= 6'(pos_q);
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// File: rtl/core/ctss_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the chiptune step sequencer synth, bound to its top level.
// Depends on ctss_pkg for the word kind codes.
module ctss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  kind,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [15:0] audio_sample,
	input logic        is_playing,
	input logic [5:0]  current_step
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_sample) &&
		$stable(current_step))
		else $error("output word changed while stalled");

	// Silence whenever playback is not running.
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_playing |-> audio_sample == 16'sd0)
		else $error("nonzero sample while stopped");

	// A tick word keeps the block busy for at least the next cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == ctss_pkg::KIND_TICK |=> !in_ready)
		else $error("input taken right after a tick");

	// A new sample appears only at the end of a busy period.
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("sample produced while idle");

endmodule

bind chiptune_step_sequencer_synth_top ctss_checker u_ctss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.kind         (kind),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.audio_sample (audio_sample),
	.is_playing   (is_playing),
	.current_step (current_step)
);
